// ----- design/lsm_pkg.sv -----
// Package for the LRU slot mapper: request and result types and shared constants.
// Used by lsm_slot_table, lru_slot_mapper and lsm_checker; depends on nothing else.
package lsm_pkg;

  // Default sizing of the slot map.
  localparam int SLOTS_DEF   = 8;
  localparam int ID_BITS_DEF = 16;

  // Fixed widths of the stream fields.
  localparam int VAR_ID_W    = 16;
  localparam int SLOT_IDX_W  = 3;
  localparam int OUT_TDATA_W = 24;

  // Request kinds carried on in_tuser.
  typedef enum logic [0:0] {
    REQ_ACQUIRE = 1'b0,
    REQ_CLEAR   = 1'b1
  } req_kind_t;

  // One request as held in the input register.
  typedef struct packed {
    req_kind_t             kind;
    logic [VAR_ID_W-1:0]   var_id;
  } req_t;

  // One result; slot_index sits in the lowest bits so the struct packs
  // straight into out_tdata.
  typedef struct packed {
    logic [VAR_ID_W-1:0]   victim_id;
    logic                  evicted;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ----- design/lsm_slot_table.sv -----
// Slot table of the LRU slot mapper: owner, busy and age registers plus the
// combinational lookup, allocation and age update logic. Depends on lsm_pkg.
module lsm_slot_table #(
  parameter int SLOTS   = lsm_pkg::SLOTS_DEF,
  parameter int ID_BITS = lsm_pkg::ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd,
  input  lsm_pkg::req_t    req,
  output lsm_pkg::result_t res
);

  localparam int IDX_W = $clog2(SLOTS);

  // Slot state.
  logic [SLOTS-1:0]               busy_r;
  logic [SLOTS-1:0]               busy_nxt;
  logic [SLOTS-1:0][IDX_W-1:0]    age_r;
  logic [SLOTS-1:0][IDX_W-1:0]    age_nxt;
  logic [SLOTS-1:0][ID_BITS-1:0]  owner_r;
  logic [SLOTS-1:0][ID_BITS-1:0]  owner_nxt;

  logic [31:0]        id_wide;
  logic [ID_BITS-1:0] id;
  logic [SLOTS-1:0]   match;
  logic [SLOTS-1:0]   oldest;
  logic [IDX_W-1:0]   hit_s;
  logic [IDX_W-1:0]   free_s;
  logic [IDX_W-1:0]   vic_s;
  logic [IDX_W-1:0]   sel_s;
  logic               hit_any;
  logic               free_any;
  logic [IDX_W-1:0]   hit_age;
  logic [31:0]        sel_wide;
  logic [31:0]        victim_wide;

  // Only the low ID_BITS bits of the identifier take part in the compare.
  assign id_wide = 32'(req.var_id);
  assign id      = id_wide[ID_BITS-1:0];

  // Associative compare and the oldest-slot marks.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = busy_r[i] && (owner_r[i] == id);
      oldest[i] = (age_r[i] == IDX_W'(SLOTS - 1));
    end
  end

  // Lowest-index priority picks for the hit, free and victim slots.
  always_comb begin
    hit_s  = '0;
    free_s = '0;
    vic_s  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_s = IDX_W'(i);
      end
      if (!busy_r[i]) begin
        free_s = IDX_W'(i);
      end
      if (oldest[i]) begin
        vic_s = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign free_any = ~&busy_r;
  assign hit_age  = age_r[hit_s];

  // The slot that ends up holding the identifier.
  always_comb begin
    if (hit_any) begin
      sel_s = hit_s;
    end else if (free_any) begin
      sel_s = free_s;
    end else begin
      sel_s = vic_s;
    end
  end

  // Next state of every slot.
  always_comb begin
    busy_nxt  = busy_r;
    age_nxt   = age_r;
    owner_nxt = owner_r;
    if (req.kind == lsm_pkg::REQ_CLEAR) begin
      busy_nxt = '0;
      age_nxt  = '0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (IDX_W'(i) == sel_s) begin
          age_nxt[i] = '0;
        end else if (busy_r[i] && (!hit_any || (age_r[i] < hit_age))) begin
          age_nxt[i] = age_r[i] + IDX_W'(1);
        end
      end
      if (!hit_any) begin
        busy_nxt[sel_s]  = 1'b1;
        owner_nxt[sel_s] = id;
      end
    end
  end

  // Result fields.
  assign sel_wide    = 32'(sel_s);
  assign victim_wide = 32'(owner_r[vic_s]);

  always_comb begin
    res = '0;
    if (req.kind != lsm_pkg::REQ_CLEAR) begin
      res.slot_index = sel_wide[lsm_pkg::SLOT_IDX_W-1:0];
      res.hit        = hit_any;
      res.evicted    = !hit_any && !free_any;
      if (!hit_any && !free_any) begin
        res.victim_id = victim_wide[lsm_pkg::VAR_ID_W-1:0];
      end
    end
  end

  // Busy bits and ages reset; owners are only read once written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      age_r  <= '0;
    end else if (upd) begin
      busy_r <= busy_nxt;
      age_r  <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      owner_r <= owner_nxt;
    end
  end

endmodule

// ----- design/lru_slot_mapper.sv -----
// Top level of the LRU slot mapper: input register, slot table and result register.
// Depends on lsm_pkg and lsm_slot_table.
//
//  Channel  Direction  Payload
//  in_      slave      tuser: req_type; tdata: var_id
//  out_     master     tdata: slot_index, hit, evicted, victim_id
//
// One request per cycle is sustained while out_tready stays high; a request is held in
// the input register, and its result is then held in the result register and shown
// on out_tdata.
// The slot table is read and updated in the cycle in which a request moves
// from the input register to the result register.
// Reset empties both registers, frees every slot and zeroes every age.
// A stalled result holds the result register, and the input register then fills.
module lru_slot_mapper #(
  parameter int SLOTS   = lsm_pkg::SLOTS_DEF,
  parameter int ID_BITS = lsm_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lsm_pkg::VAR_ID_W-1:0]    in_tdata,   // [15:0] var_id
  input  logic [0:0]                      in_tuser,   // [0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] slot_index, [3] hit, [4] evicted, [20:5] victim_id, [23:21] zero
  output logic [lsm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic             in_valid_r;
  logic             in_valid_nxt;
  lsm_pkg::req_t    req_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  lsm_pkg::result_t res_r;
  lsm_pkg::result_t res;
  logic             advance;
  logic             in_take;

  // A request moves on when the result register is empty or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.kind   <= lsm_pkg::req_kind_t'(in_tuser);
      req_r.var_id <= in_tdata;
    end
  end

  // Slot table, updated as the request advances.
  lsm_slot_table #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .req   (req_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(lsm_pkg::OUT_TDATA_W - lsm_pkg::RESULT_W)'(0), res_r};

endmodule

// ----- design/lsm_checker.sv -----
// Port-level checker for the LRU slot mapper, bound to lru_slot_mapper.
// Depends on lsm_pkg for the field widths.
module lsm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lsm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Requests taken whose results are not yet delivered.
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A hit never evicts and never reports a victim.
  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[4] && (out_tdata[20:5] == '0))
    else $error("hit result carries an eviction");

  // Without an eviction the victim field is zero.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> (out_tdata[20:5] == '0))
    else $error("victim reported without eviction");

  // At most two transactions are in flight, and a result needs one of them.
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3) && (!out_tvalid || (pend_r != 2'd0)))
    else $error("request and result counts disagree");

endmodule

bind lru_slot_mapper lsm_checker u_lsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
